// ===== hdl/ckerng_pkg.sv =====
// ============================================================================
// ChaCha20 key-erasure generator package
// Shared constants and the quarter-round function.
// ============================================================================
package ckerng_pkg;

    localparam int unsigned RESERVE_WORDS_DEF = 128;
    localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
    localparam int unsigned CFG_REGS          = 4;
    localparam int unsigned CFG_IDX_W         = 2;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic OP_RAW     = 1'b0;
    localparam logic OP_UNIFORM = 1'b1;

    typedef logic [31:0] word_t;
    typedef word_t [3:0] quad_t;

    // Controls handed from the sequencer to the cipher core.
    typedef struct packed {
        logic start;     // begin one block
        logic load_key;  // load constants, key and zero counter first
    } core_ctl_t;

    // One full ChaCha quarter round on four words.
    function automatic quad_t quarter_round(input quad_t q);
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        quad_t r;
        a = q[0]; b = q[1]; c = q[2]; d = q[3];
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        r[0] = a; r[1] = b; r[2] = c; r[3] = d;
        return r;
    endfunction

endpackage

// ===== hdl/chacha20_key_erasure_rng.sv =====
// ============================================================================
// ChaCha20 fast-key-erasure random word generator
// Keeps a key and a reserve of words refilled by the ChaCha block function.
// ============================================================================
//  channel  | signals                                    | direction
//  input    | in_valid, in_ready, operation, value_bound | in, in_ready out
//  output   | out_valid, out_ready, random_value         | out, out_ready in
//  config   | cfg_we, cfg_index, cfg_data                | in
//
//  A raw draw from a stocked reserve passes through S_CHECK, S_READ and S_OUT
//  before out_valid rises. A refill runs each ChaCha block on the shared
//  quarter-round unit and copies reserve blocks in one word per cycle; it
//  runs RESERVE/16+1 blocks in all. Uniform mode adds two serial modulo
//  passes and repeats the draw on rejection. Reset leaves the reserve memory
//  undefined; in_ready stays low until the result transaction completes.
module chacha20_key_erasure_rng #(
    parameter int unsigned RESERVE_WORDS = ckerng_pkg::RESERVE_WORDS_DEF,
    parameter int unsigned DOUBLE_ROUNDS = ckerng_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             operation,
    input  logic [31:0]                      value_bound,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [31:0]                      random_value,
    input  logic                             cfg_we,
    input  logic [ckerng_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data
);
    import ckerng_pkg::*;

    localparam int unsigned AW  = $clog2(RESERVE_WORDS);
    localparam int unsigned OW  = $clog2(RESERVE_WORDS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_LIM, S_LIMW, S_CHECK, S_KEYBLK, S_KEYW, S_BLK, S_BLKW,
        S_WRITE, S_READ, S_MOD, S_MODW, S_OUT
    } state_t;

    state_t          state_reg;
    logic [63:0]     seed_reg [CFG_REGS];
    word_t           key_reg [8];
    logic            started_reg;
    logic [OW-1:0]   offset_reg;
    logic [OW-1:0]   pos_reg;
    logic [3:0]      widx_reg;
    logic            op_reg;
    word_t           bound_reg;
    word_t           lim_reg;
    word_t           word_reg;
    word_t           result_reg;
    logic            out_valid_reg;
    word_t           mem [RESERVE_WORDS];
    word_t           rd_reg;

    core_ctl_t       cctl;
    logic            core_done;
    word_t           blk [16];
    logic            mstart;
    word_t           mnum;
    logic            mdone;
    word_t           mrem;

    ckerng_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .clk(clk), .rst_n(rst_n), .ctl(cctl), .key(key_reg),
        .done(core_done), .blk(blk)
    );

    ckerng_mod u_mod (
        .clk(clk), .rst_n(rst_n), .start(mstart), .num(mnum), .den(bound_reg),
        .done(mdone), .rem(mrem)
    );

    // Start pulses for the shared units.
    always_comb
    begin
        cctl.start    = (state_reg == S_KEYBLK) || (state_reg == S_BLK);
        cctl.load_key = (state_reg == S_KEYBLK);
        mstart        = (state_reg == S_LIM) || (state_reg == S_MOD);
        mnum          = (state_reg == S_LIM) ? (32'd0 - bound_reg) : word_reg;
    end

    assign in_ready     = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign random_value = result_reg;

    // Reserve memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WRITE)
            mem[pos_reg[AW-1:0]] <= blk[widx_reg];
        else if (state_reg == S_READ)
            mem[offset_reg[AW-1:0]] <= '0;
        rd_reg <= mem[offset_reg[AW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
                seed_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            seed_reg[cfg_index] <= cfg_data;
        end
    end

    // Main sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            offset_reg    <= OW'(RESERVE_WORDS);
            pos_reg       <= '0;
            widx_reg      <= '0;
            op_reg        <= OP_RAW;
            bound_reg     <= '0;
            lim_reg       <= '0;
            word_reg      <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                key_reg[i] <= '0;
        end
        else
        begin
            // The result stays valid until its transaction completes.
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        op_reg    <= operation;
                        bound_reg <= value_bound;
                        if (!started_reg)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                key_reg[2*i]   <= seed_reg[i][31:0];
                                key_reg[2*i+1] <= seed_reg[i][63:32];
                            end
                            offset_reg  <= OW'(RESERVE_WORDS);
                            started_reg <= 1'b1;
                        end
                        if (operation == OP_UNIFORM && value_bound < 32'd2)
                        begin
                            result_reg <= '0;
                            state_reg  <= S_OUT;
                        end
                        else if (operation == OP_UNIFORM)
                            state_reg <= S_LIM;
                        else
                            state_reg <= S_CHECK;
                    end
                end
                S_LIM:  state_reg <= S_LIMW;
                S_LIMW:
                begin
                    if (mdone)
                    begin
                        lim_reg   <= mrem;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (offset_reg >= OW'(RESERVE_WORDS))
                        state_reg <= S_KEYBLK;
                    else
                        state_reg <= S_READ;
                end
                S_KEYBLK: state_reg <= S_KEYW;
                S_KEYW:
                begin
                    // Block zero replaces the key.
                    if (core_done)
                    begin
                        for (int i = 0; i < 8; i++)
                            key_reg[i] <= blk[i];
                        pos_reg   <= '0;
                        state_reg <= S_BLK;
                    end
                end
                S_BLK:    state_reg <= S_BLKW;
                S_BLKW:
                begin
                    if (core_done)
                    begin
                        widx_reg  <= 4'd0;
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    // Copy the block into the reserve one word per cycle.
                    pos_reg  <= pos_reg + OW'(1);
                    widx_reg <= widx_reg + 4'd1;
                    if (pos_reg == OW'(RESERVE_WORDS - 1))
                    begin
                        offset_reg <= '0;
                        state_reg  <= S_CHECK;
                    end
                    else if (widx_reg == 4'd15)
                        state_reg <= S_BLK;
                end
                S_READ:
                begin
                    // The word is cleared in the reserve as it is taken.
                    word_reg   <= rd_reg;
                    offset_reg <= offset_reg + OW'(1);
                    if (op_reg == OP_RAW)
                    begin
                        result_reg <= rd_reg;
                        state_reg  <= S_OUT;
                    end
                    else if (rd_reg < lim_reg)
                        state_reg <= S_CHECK;
                    else
                        state_reg <= S_MOD;
                end
                S_MOD:  state_reg <= S_MODW;
                S_MODW:
                begin
                    if (mdone)
                    begin
                        result_reg <= mrem;
                        state_reg  <= S_OUT;
                    end
                end
                S_OUT:  state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/ckerng_core.sv =====
// ============================================================================
// ChaCha block core
// One shared quarter-round unit applied eight times per double round.
// ============================================================================
module ckerng_core #(
    parameter int unsigned DOUBLE_ROUNDS = ckerng_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ckerng_pkg::core_ctl_t ctl,
    input  ckerng_pkg::word_t     key [8],
    output logic                  done,
    output ckerng_pkg::word_t     blk [16]
);
    import ckerng_pkg::*;

    localparam int unsigned DR_W = $clog2(DOUBLE_ROUNDS + 1);

    typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FINAL} state_t;

    state_t          state_reg;
    logic [2:0]      qr_reg;
    logic [DR_W-1:0] dr_reg;
    word_t           base_reg [16];
    word_t           work_reg [16];
    logic            done_reg;

    logic [3:0] ia, ib, ic, id;
    quad_t      qin, qout;

    // Word indices for the column and diagonal quarter rounds.
    always_comb
    begin
        ia = {2'b00, qr_reg[1:0]};
        ib = {2'b01, qr_reg[1:0]};
        ic = {2'b10, qr_reg[1:0]};
        id = {2'b11, qr_reg[1:0]};
        if (qr_reg[2])
        begin
            ib = {2'b01, qr_reg[1:0] + 2'd1};
            ic = {2'b10, qr_reg[1:0] + 2'd2};
            id = {2'b11, qr_reg[1:0] + 2'd3};
        end
        qin[0] = work_reg[ia];
        qin[1] = work_reg[ib];
        qin[2] = work_reg[ic];
        qin[3] = work_reg[id];
        qout   = quarter_round(qin);
    end

    // Sequencer, working state and feed-forward output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            qr_reg    <= '0;
            dr_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.start)
                    begin
                        if (ctl.load_key)
                        begin
                            base_reg[0] <= SIGMA0; base_reg[1] <= SIGMA1;
                            base_reg[2] <= SIGMA2; base_reg[3] <= SIGMA3;
                            work_reg[0] <= SIGMA0; work_reg[1] <= SIGMA1;
                            work_reg[2] <= SIGMA2; work_reg[3] <= SIGMA3;
                            for (int i = 0; i < 8; i++)
                            begin
                                base_reg[4+i] <= key[i];
                                work_reg[4+i] <= key[i];
                            end
                            for (int i = 12; i < 16; i++)
                            begin
                                base_reg[i] <= '0;
                                work_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < 16; i++)
                                work_reg[i] <= base_reg[i];
                        end
                        qr_reg    <= '0;
                        dr_reg    <= '0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    work_reg[ia] <= qout[0];
                    work_reg[ib] <= qout[1];
                    work_reg[ic] <= qout[2];
                    work_reg[id] <= qout[3];
                    qr_reg <= qr_reg + 3'd1;
                    if (qr_reg == 3'd7)
                    begin
                        dr_reg <= dr_reg + DR_W'(1);
                        if (dr_reg == DR_W'(DOUBLE_ROUNDS - 1))
                            state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    for (int i = 0; i < 16; i++)
                        blk[i] <= work_reg[i] + base_reg[i];
                    base_reg[12] <= base_reg[12] + 32'd1;
                    done_reg     <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;

endmodule

// ===== hdl/ckerng_mod.sv =====
// ============================================================================
// Serial modulo unit
// Restoring remainder, one dividend bit per cycle.
// ============================================================================
module ckerng_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ckerng_pkg::word_t num,
    input  ckerng_pkg::word_t den,
    output logic              done,
    output ckerng_pkg::word_t rem
);
    import ckerng_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    word_t       num_reg;
    word_t       den_reg;
    logic [32:0] rem_reg;
    logic        done_reg;
    logic [32:0] shifted;

    assign shifted = {rem_reg[31:0], num_reg[31]};

    // One shift-and-subtract step per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[30:0], 1'b0};
                if (shifted >= {1'b0, den_reg})
                    rem_reg <= shifted - {1'b0, den_reg};
                else
                    rem_reg <= shifted;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[31:0];

endmodule

// ===== verif/ckerng_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Key-erasure generator checker
// Watches the configuration port and both channels, predicts every random
// value with its own ChaCha20 key-erasure generator and compares in order.
// ============================================================================
module ckerng_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             operation,
    input  logic [31:0]                      value_bound,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [31:0]                      random_value,
    input  logic                             cfg_we,
    input  logic [ckerng_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                      cfg_data,
    output int                               errors,
    output int                               pending
);
    import ckerng_pkg::*;

    localparam int unsigned POOL = RESERVE_WORDS_DEF;

    // Model state.
    logic [63:0] seed_reg [CFG_REGS];
    word_t       key_words [8];
    word_t       pool [POOL];
    int unsigned pool_pos;
    logic        running;
    word_t       value_queue [$];

    function automatic void mix(inout word_t a, inout word_t b,
                                inout word_t c, inout word_t d);
        a = a + b; d = d ^ a; d = (d << 16) | (d >> 16);
        c = c + d; b = b ^ c; b = (b << 12) | (b >> 20);
        a = a + b; d = d ^ a; d = (d << 8) | (d >> 24);
        c = c + d; b = b ^ c; b = (b << 7) | (b >> 25);
    endfunction

    // One ChaCha20 block from the given state words.
    function automatic void cipher_block(input word_t st [16], output word_t blk [16]);
        word_t w [16];
        w = st;
        for (int r = 0; r < DOUBLE_ROUNDS_DEF; r++)
        begin
            mix(w[0], w[4], w[8], w[12]);
            mix(w[1], w[5], w[9], w[13]);
            mix(w[2], w[6], w[10], w[14]);
            mix(w[3], w[7], w[11], w[15]);
            mix(w[0], w[5], w[10], w[15]);
            mix(w[1], w[6], w[11], w[12]);
            mix(w[2], w[7], w[8], w[13]);
            mix(w[3], w[4], w[9], w[14]);
        end
        for (int i = 0; i < 16; i++)
            blk[i] = w[i] + st[i];
    endfunction

    // Block zero replaces the key; the following blocks fill the pool.
    function automatic void rekey_and_fill();
        word_t st [16];
        word_t blk [16];
        st[0] = SIGMA0; st[1] = SIGMA1; st[2] = SIGMA2; st[3] = SIGMA3;
        for (int i = 0; i < 8; i++)
            st[4 + i] = key_words[i];
        for (int i = 12; i < 16; i++)
            st[i] = '0;
        cipher_block(st, blk);
        for (int i = 0; i < 8; i++)
            key_words[i] = blk[i];
        for (int b = 0; b * 16 < POOL; b++)
        begin
            st[12] = word_t'(b + 1);
            cipher_block(st, blk);
            for (int i = 0; i < 16 && b * 16 + i < POOL; i++)
                pool[b * 16 + i] = blk[i];
        end
        pool_pos = 0;
    endfunction

    function automatic word_t take_word();
        word_t v;
        if (pool_pos >= POOL)
            rekey_and_fill();
        v = pool[pool_pos];
        pool[pool_pos] = '0;
        pool_pos++;
        return v;
    endfunction

    function automatic word_t predict_value(input logic op, input word_t bound);
        word_t v;
        word_t floor_val;
        if (!running)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_words[2 * i]     = seed_reg[i][31:0];
                key_words[2 * i + 1] = seed_reg[i][63:32];
            end
            pool_pos = POOL;
            running  = 1'b1;
        end
        if (op == OP_RAW)
            v = take_word();
        else if (bound < 32'd2)
            v = '0;
        else
        begin
            floor_val = (32'd0 - bound) % bound;
            do
                v = take_word();
            while (v < floor_val);
            v = v % bound;
        end
        return v;
    endfunction

    // Track configuration writes and both transactions.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_REGS; i++)
                seed_reg[i] = '0;
            pool_pos = POOL;
            running  = 1'b0;
            errors   = 0;
            value_queue.delete();
        end
        else
        begin
            if (cfg_we)
                seed_reg[cfg_index] = cfg_data;
            if (in_valid && in_ready)
                value_queue.push_back(predict_value(operation, value_bound));
            if (out_valid && out_ready)
            begin
                if (value_queue.size() == 0)
                begin
                    $display("%0t: unexpected random_value expected none actual %h",
                             $time, random_value);
                    errors++;
                end
                else
                begin
                    if (value_queue[0] !== random_value)
                    begin
                        $display("%0t: random_value mismatch expected %h actual %h",
                                 $time, value_queue[0], random_value);
                        errors++;
                    end
                    void'(value_queue.pop_front());
                end
            end
        end
        pending = value_queue.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Key-erasure generator testbench
// Drives raw and uniform requests with random idling on both channels and
// leaves the checking to the checker module beside the block.
// ============================================================================
module tb;
    import ckerng_pkg::*;

    localparam logic [CFG_IDX_W-1:0] SEED_KEY_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] SEED_KEY_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] SEED_KEY_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] SEED_KEY_3 = CFG_IDX_W'(3);
    localparam int RANDOM_REQUESTS = 1830;
    localparam int STALL_LIMIT     = 40000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 operation = OP_RAW;
    logic [31:0]          value_bound = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [31:0]          random_value;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = SEED_KEY_0;
    logic [63:0]          cfg_data = '0;
    int                   errors;
    int                   pending;
    logic                 steady = 1'b0;
    int                   quiet_cycles = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    chacha20_key_erasure_rng DUT (.*);

    ckerng_checker u_checker (.*);

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side stalls in bursts until the closing part.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!steady && $urandom_range(0, 3) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready = 1'b1;
            if (!steady)
                repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_seed(input logic [63:0] v0, input logic [63:0] v1,
                              input logic [63:0] v2, input logic [63:0] v3);
        write_reg(SEED_KEY_0, v0);
        write_reg(SEED_KEY_1, v1);
        write_reg(SEED_KEY_2, v2);
        write_reg(SEED_KEY_3, v3);
    endtask

    // One request transaction, then possibly an idle burst.
    task automatic request(input logic op, input logic [31:0] bound);
        @(negedge clk);
        in_valid    = 1'b1;
        operation   = op;
        value_bound = bound;
        do
            @(posedge clk);
        while (!in_ready);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(1, 16) - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1);
            1, 2:    return $urandom_range(2, 100);
            3, 4:    return 32'h8000_0000 + $urandom_range(1, 1000);
            5:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Seed key with mixed extremes in its words.
        write_seed(64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom},
                   64'h0000_0000_0000_0000, {$urandom, $urandom});

        // Directed requests: bound extremes, both operations, heavy rejection.
        request(OP_RAW, 32'h0);
        request(OP_UNIFORM, 32'd0);
        request(OP_UNIFORM, 32'd1);
        request(OP_UNIFORM, 32'd2);
        request(OP_UNIFORM, 32'd3);
        request(OP_UNIFORM, 32'hFFFF_FFFF);
        request(OP_UNIFORM, 32'h8000_0000);
        request(OP_UNIFORM, 32'h8000_0001);
        request(OP_UNIFORM, 32'hC000_0001);
        request(OP_UNIFORM, 32'h5555_5555);
        request(OP_RAW, 32'hFFFF_FFFF);
        request(OP_UNIFORM, 32'h0000_0007);
        request(OP_UNIFORM, 32'hAAAA_AAAA);
        request(OP_UNIFORM, 32'h5555_5555);
        for (int i = 0; i < 6; i++)
            request(OP_UNIFORM, 32'h8000_0001);

        // Random requests; register writes between phases must not rekey.
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            if (i == 600 || i == 1200)
            begin
                drain();
                if (i == 600)
                    write_seed('1, '1, '1, '1);
                else
                    write_seed('0, {$urandom, $urandom}, '0, '1);
            end
            if (i == RANDOM_REQUESTS - 200)
                steady = 1'b1;
            request($urandom_range(0, 1) ? OP_UNIFORM : OP_RAW, pick_bound());
        end

        drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
